[hdl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Word type, round constants, initial hash value, sigma functions, state
// types and the control bundle passed from the sequencer to the round unit.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t PAD_MARKER = 32'h80000000;
  localparam logic [3:0] LEN_HI_POS = 4'd14;
  localparam logic [3:0] LAST_POS = 4'd15;
  localparam logic [2:0] FULL_BYTES = 3'd4;
  localparam logic [2:0] LAST_INDEX = 3'd7;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_START,
    ST_WAIT,
    ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ROUND,
    PH_FINAL
  } core_phase_t;

  typedef struct packed {
    logic push;
    logic start;
    logic init;
  } core_ctl_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hdl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Gathers message words into blocks, pads the final block and emits the
// eight digest words through a shared one-round-per-cycle compression unit.
// ----------------------------------------------------------------------------
// The message enters on the in_ channel as big-endian words. in_tlast marks
// the last word, and in_tuser gives its count of valid leading bytes (0 to 4).
// A non-final word is taken whenever in_tready is high. Every sixteenth
// word starts a compression (a start state, 64 rounds, a chaining add
// and a return to idle), during which in_tready is low and no word is taken.
// After the final word the block pushes padding words at one per cycle up to
// the end of the block, compresses, and may need one more padded block.
// The eight digest words then leave on the out_ channel, H0 first, with the
// word index in out_tuser and out_tlast on the eighth. A stall on out_tready
// holds the current word; no input is taken until all eight are delivered.
// After the eighth word the chaining value, word count and bit length return
// to their reset values. Reset clears all control state at once and leaves
// the block ready for a new message; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // message_word[31:0]
  input  logic [2:0]  in_tuser,   // valid_bytes[2:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word[31:0]
  output logic [2:0]  out_tuser,  // digest_index[2:0]
  output logic        out_tlast
);

  seq_state_t  state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [63:0] len_r, len_nxt;
  logic        marker_r, marker_nxt;
  logic        hi_sent_r, hi_sent_nxt;
  logic        fin_r, fin_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  idx_r, idx_nxt;
  core_ctl_t   ctl;
  word_t       push_word;
  word_t       digest;
  logic        busy;
  logic [2:0]  nbytes;
  word_t       keep_mask;
  word_t       tail_marker;
  logic        out_acc;

  sha256_round_unit u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .push_word (push_word),
    .rd_idx    (idx_r),
    .rd_word   (digest),
    .busy      (busy)
  );

  assign out_acc = out_tvalid && out_tready;
  assign nbytes  = (in_tuser > FULL_BYTES) ? FULL_BYTES : in_tuser;

  always_comb begin
    case (nbytes)
      3'd0: begin
        keep_mask   = 32'h00000000;
        tail_marker = 32'h80000000;
      end
      3'd1: begin
        keep_mask   = 32'hFF000000;
        tail_marker = 32'h00800000;
      end
      3'd2: begin
        keep_mask   = 32'hFFFF0000;
        tail_marker = 32'h00008000;
      end
      3'd3: begin
        keep_mask   = 32'hFFFFFF00;
        tail_marker = 32'h00000080;
      end
      default: begin
        keep_mask   = 32'hFFFFFFFF;
        tail_marker = 32'h00000000;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    bitlen_nxt  = bitlen_r;
    len_nxt     = len_r;
    marker_nxt  = marker_r;
    hi_sent_nxt = hi_sent_r;
    fin_nxt     = fin_r;
    done_nxt    = done_r;
    idx_nxt     = idx_r;
    ctl         = '0;
    push_word   = '0;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.push = 1'b1;
          pos_nxt  = pos_r + 4'd1;
          if (!in_tlast) begin
            push_word  = in_tdata;
            bitlen_nxt = bitlen_r + 64'd32;
            if (pos_r == LAST_POS) begin
              state_nxt = ST_START;
            end
          end else begin
            push_word   = (in_tdata & keep_mask) | tail_marker;
            len_nxt     = bitlen_r + {58'd0, nbytes, 3'd0};
            marker_nxt  = (nbytes == FULL_BYTES);
            hi_sent_nxt = 1'b0;
            done_nxt    = 1'b0;
            fin_nxt     = 1'b1;
            state_nxt   = (pos_r == LAST_POS) ? ST_START : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        pos_nxt  = pos_r + 4'd1;
        if (marker_r) begin
          push_word  = PAD_MARKER;
          marker_nxt = 1'b0;
        end else if (hi_sent_r) begin
          push_word = len_r[31:0];
          done_nxt  = 1'b1;
        end else if (pos_r == LEN_HI_POS) begin
          push_word   = len_r[63:32];
          hi_sent_nxt = 1'b1;
        end
        if (pos_r == LAST_POS) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        ctl.start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (!busy) begin
          if (!fin_r) begin
            state_nxt = ST_IDLE;
          end else if (done_r) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_INDEX) begin
            ctl.init   = 1'b1;
            pos_nxt    = '0;
            bitlen_nxt = '0;
            fin_nxt    = 1'b0;
            done_nxt   = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      bitlen_r  <= '0;
      marker_r  <= 1'b0;
      hi_sent_r <= 1'b0;
      fin_r     <= 1'b0;
      done_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      bitlen_r  <= bitlen_nxt;
      marker_r  <= marker_nxt;
      hi_sent_r <= hi_sent_nxt;
      fin_r     <= fin_nxt;
      done_r    <= done_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  assign out_tdata = digest;
  assign out_tuser = idx_r;
  assign out_tlast = (idx_r == LAST_INDEX);

`ifndef NO_ASSERTIONS
  a_ready_excl_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("Input request taken while digest output is pending.");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |=> busy)
    else $error("Round unit did not start on a start request.");

  a_digest_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && idx_r == LAST_INDEX) |=> (pos_r == '0 && bitlen_r == '0 && idx_r == '0))
    else $error("Message state not cleared after the last digest word.");

  a_start_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |-> (pos_r == '0))
    else $error("Compression started on a partial block.");
`endif

endmodule

[hdl/sha256_round_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the message window, the working variables and the chaining value,
// and runs one compression round per cycle for 64 rounds.
// ----------------------------------------------------------------------------
module sha256_round_unit
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  core_ctl_t ctl,
  input  word_t     push_word,
  input  logic [2:0] rd_idx,
  output word_t     rd_word,
  output logic      busy
);

  core_phase_t phase_r, phase_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  word_t       win_r [16];
  word_t       var_r [8];
  word_t       hash_r [8];
  word_t       t1, t2, ch, maj, sched;

  always_comb begin
    ch    = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    maj   = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t1    = var_r[7] + big_sigma1(var_r[4]) + ch + ROUND_K[rnd_r] + win_r[0];
    t2    = big_sigma0(var_r[0]) + maj;
    sched = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
  end

  always_comb begin
    phase_nxt = phase_r;
    rnd_nxt   = rnd_r;
    case (phase_r)
      PH_IDLE: begin
        if (ctl.start) begin
          phase_nxt = PH_ROUND;
          rnd_nxt   = '0;
        end
      end
      PH_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          phase_nxt = PH_FINAL;
        end
      end
      PH_FINAL: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rnd_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push || phase_r == PH_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= (phase_r == PH_ROUND) ? sched : push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && ctl.start) begin
      for (int i = 0; i < 8; i++) begin
        var_r[i] <= hash_r[i];
      end
    end else if (phase_r == PH_ROUND) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= INIT_HASH[i];
      end
    end else if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= INIT_HASH[i];
      end
    end else if (phase_r == PH_FINAL) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + var_r[i];
      end
    end
  end

  assign rd_word = hash_r[rd_idx];
  assign busy    = (phase_r != PH_IDLE);

endmodule

[tb/tb_sha256_stream_hasher.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// A short table of directed messages runs first, two of them with known
// digests typed in. Random messages of mostly short lengths follow. Every
// accepted word updates a SHA-256 model in the testbench, and each digest
// word leaving the block is checked in order against it or the typed digest.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;

  localparam int ITEM_TARGET = 330;
  localparam int QUIET_ITEMS = 50;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 200;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [2:0] WHOLE_WORD = 3'd4;
  localparam logic [3:0] LENGTH_POS = 4'd14;
  localparam logic [2:0] FINAL_INDEX = 3'd7;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        done;
  } digest_word_t;

  typedef struct {
    logic [31:0]  word;
    logic [2:0]   nbytes;
    logic         fin;
    bit           has_typed;
    logic [255:0] typed;
  } msg_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // message_word[31:0]
  logic [2:0]  in_tuser;   // valid_bytes[2:0]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // digest_word[31:0]
  logic [2:0]  out_tuser;  // digest_index[2:0]
  logic        out_tlast;

  logic [31:0]  chain_h [8];
  logic [31:0]  block_buf [16];
  logic [3:0]   fill_pos;
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];
  msg_row_t     msg_rows [$];
  int           item_count;
  int           fail_count;
  int           stall_cycles;
  bit           quiet;

  sha256_stream_hasher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_hash_state();
    for (int i = 0; i < 8; i++) chain_h[i] = START_HASH[i];
    fill_pos = '0;
    msg_bits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) sched[t] = block_buf[t];
    for (int t = 16; t < 64; t++) begin
      sched[t] = (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10))
               + sched[t-7]
               + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
               + sched[t-16];
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[t] + sched[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic load_word(input logic [31:0] w);
    block_buf[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) compress_block();
  endtask

  task automatic hash_request(input logic [31:0] w, input logic [2:0] nbytes, input logic fin,
                              input bit has_typed, input logic [255:0] typed);
    logic [2:0]   used;
    logic [63:0]  total;
    int           shamt;
    digest_word_t dw;
    if (!fin) begin
      msg_bits = msg_bits + 64'd32;
      load_word(w);
    end else begin
      used = (nbytes > WHOLE_WORD) ? WHOLE_WORD : nbytes;
      msg_bits = msg_bits + {58'd0, used, 3'd0};
      total = msg_bits;
      if (used == WHOLE_WORD) begin
        load_word(w);
        load_word(PAD_WORD);
      end else begin
        shamt = 8 * used;
        load_word((w & ~(32'hFFFF_FFFF >> shamt)) | (32'h80 << (24 - shamt)));
      end
      while (fill_pos != LENGTH_POS) load_word(32'd0);
      load_word(total[63:32]);
      load_word(total[31:0]);
      for (int i = 0; i < 8; i++) begin
        dw.word = has_typed ? typed[255 - 32*i -: 32] : chain_h[i];
        dw.index = i[2:0];
        dw.done = (i[2:0] == FINAL_INDEX);
        digest_q.push_back(dw);
      end
      clear_hash_state();
    end
  endtask

  task automatic add_row(input logic [31:0] w, input logic [2:0] nbytes, input logic fin,
                         input bit has_typed = 1'b0, input logic [255:0] typed = '0);
    msg_row_t r;
    r.word = w;
    r.nbytes = nbytes;
    r.fin = fin;
    r.has_typed = has_typed;
    r.typed = typed;
    msg_rows.push_back(r);
  endtask

  task automatic send_word(input logic [31:0] w, input logic [2:0] nbytes, input logic fin,
                           input bit gappy, input bit has_typed = 1'b0,
                           input logic [255:0] typed = '0);
    if (gappy && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= nbytes;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hash_request(w, nbytes, fin, has_typed, typed);
    item_count++;
    @(negedge clk);
  endtask

  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : digest_check
    digest_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest_word %h arrived with no request pending", out_tdata);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.index) begin
          $error("digest_index: expected %0d, got %0d", want.index, out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.done) begin
          $error("digest_done: expected %0b, got %0b", want.done, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int msg_len;
    bit gappy;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    item_count = 0;
    fail_count = 0;
    stall_cycles = 0;
    quiet = 1'b0;
    clear_hash_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The empty message, then "abc" with a stray byte past the valid ones.
    add_row(32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST);
    add_row(32'h6162_63A5, 3'd3, 1'b1, 1'b1, ABC_DIGEST);
    add_row(32'hFFFF_FFFF, 3'd4, 1'b1);
    add_row(32'hFFFF_FFFF, 3'd1, 1'b1);
    add_row(32'hFFFF_FFFF, 3'd7, 1'b0);
    add_row(32'hFFFF_FFFF, 3'd2, 1'b1);
    add_row(32'h0000_0000, 3'd0, 1'b0);
    add_row(32'h1234_5678, 3'd7, 1'b1);
    add_row(32'hDEAD_BEEF, 3'd3, 1'b0);
    add_row(32'hFFFF_FFFF, 3'd0, 1'b1);
    add_row(32'hFFFF_FFFF, 3'd6, 1'b1);
    // Fourteen words leave no room for the length, so padding spills over.
    for (int i = 0; i < 13; i++) begin
      add_row((i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'(i % 8), 1'b0);
    end
    add_row(32'hA5A5_A5A5, 3'd5, 1'b1);

    foreach (msg_rows[i]) begin
      send_word(msg_rows[i].word, msg_rows[i].nbytes, msg_rows[i].fin, 1'b1,
                msg_rows[i].has_typed, msg_rows[i].typed);
    end

    while (item_count < ITEM_TARGET) begin
      gappy = ($urandom_range(0, 2) != 0);
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 20);
      for (int i = 0; i < msg_len; i++) begin
        quiet = (item_count >= ITEM_TARGET - QUIET_ITEMS);
        send_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : WHOLE_WORD,
                  1'b0, gappy);
      end
      quiet = (item_count >= ITEM_TARGET - QUIET_ITEMS);
      send_word($urandom, ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4)),
                1'b1, gappy);
    end
    in_tvalid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sha256_pkg.sv
hdl/sha256_round_unit.sv
hdl/sha256_stream_hasher.sv
tb/tb_sha256_stream_hasher.sv
